### rtl/core/gtpie_pkg.sv
// gtpie_pkg: types and constants shared by the gtpv2 ie tlv deframer core
// no dependencies; imported by gtpie_parser and gtpv2_ie_tlv_deframer_core
package gtpie_pkg;

  typedef enum logic [1:0] {
    CLS_HEADER  = 2'd0,
    CLS_VALUE   = 2'd1,
    CLS_DISCARD = 2'd2
  } byte_class_t;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_HEADER = 2'd1,
    STOP_VALUE  = 2'd2
  } stop_reason_t;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_INST   = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  localparam logic [13:0] COUNT_MAX   = 14'h3FFF;
  localparam int          HDR_BYTES   = 4;
  localparam logic [7:0]  INST_MASK   = 8'h0F;
  localparam logic [7:0]  CR_MASK     = 8'h08;
  localparam int          OUT_TDATA_W = 72;

  typedef struct packed {
    byte_class_t  byte_class;
    stop_reason_t stop_reason;
    logic [7:0]   ie_type;
    logic [15:0]  ie_len;
    logic [3:0]   ie_instance;
    logic         cr_flag;
    logic [15:0]  value_index;
    logic [7:0]   value_byte;
    logic         ie_complete;
    logic [13:0]  ie_count;
    logic         buffer_end;
  } gtpie_result_t;

endpackage

### rtl/core/gtpie_parser.sv
// gtpie_parser: per-buffer parse state and the classification logic for one item
// depends on gtpie_pkg; state advances only when step is high
module gtpie_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic                    first,
  input  logic [15:0]             buffer_length,
  output gtpie_pkg::gtpie_result_t result
);
  import gtpie_pkg::*;

  localparam int EW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;

  logic [LENGTH_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [LENGTH_BITS-1:0] total_length_r, total_length_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             held_type_r, held_type_nxt;
  logic [15:0]            held_length_r, held_length_nxt;
  logic [4:0]             held_inst_cr_r, held_inst_cr_nxt;
  logic [15:0]            value_counter_r, value_counter_nxt;
  stop_reason_t           stopped_r, stopped_nxt;
  logic [13:0]            accepted_r, accepted_nxt;

  logic [LENGTH_BITS-1:0] off;
  phase_t                 phase_cur;
  logic [15:0]            hl_cur;
  logic [15:0]            vc_cur;
  stop_reason_t           sr_cur;
  logic [13:0]            ac_cur;
  logic [EW-1:0]          off_e, tl_e;
  logic                   active;
  byte_class_t            cls;
  logic                   done;
  logic [15:0]            vidx;
  logic [7:0]             vbyte;

  always_comb begin
    total_length_nxt = first ? LENGTH_BITS'(buffer_length) : total_length_r;
    off              = first ? '0 : byte_offset_r;
    phase_cur        = first ? PH_TYPE : phase_r;
    held_type_nxt    = first ? 8'd0 : held_type_r;
    hl_cur           = first ? 16'd0 : held_length_r;
    held_inst_cr_nxt = first ? 5'd0 : held_inst_cr_r;
    vc_cur           = first ? 16'd0 : value_counter_r;
    sr_cur           = first ? STOP_NONE : stopped_r;
    ac_cur           = first ? 14'd0 : accepted_r;

    off_e  = EW'(off);
    tl_e   = EW'(total_length_nxt);
    active = (sr_cur == STOP_NONE) && (off < total_length_nxt);

    phase_nxt         = phase_cur;
    held_length_nxt   = hl_cur;
    value_counter_nxt = vc_cur;
    stopped_nxt       = sr_cur;
    accepted_nxt      = ac_cur;
    cls               = CLS_DISCARD;
    done              = 1'b0;
    vidx              = 16'd0;
    vbyte             = 8'd0;

    if (active) begin
      unique case (phase_cur)
        PH_TYPE: begin
          if (off_e + EW'(HDR_BYTES) > tl_e) begin
            stopped_nxt = STOP_HEADER;
          end else begin
            held_type_nxt    = data_byte;
            held_length_nxt  = 16'd0;
            held_inst_cr_nxt = 5'd0;
            phase_nxt        = PH_LEN_HI;
            cls              = CLS_HEADER;
          end
        end
        PH_LEN_HI: begin
          held_length_nxt = {data_byte, 8'd0};
          phase_nxt       = PH_LEN_LO;
          cls             = CLS_HEADER;
        end
        PH_LEN_LO: begin
          held_length_nxt = {hl_cur[15:8], data_byte};
          phase_nxt       = PH_INST;
          cls             = CLS_HEADER;
        end
        PH_INST: begin
          held_inst_cr_nxt = {data_byte[7:4] & INST_MASK[3:0], |(data_byte & CR_MASK)};
          cls              = CLS_HEADER;
          if (off_e + EW'(1) + EW'(hl_cur) > tl_e) begin
            stopped_nxt = STOP_VALUE;
          end else if (hl_cur == 16'd0) begin
            done      = 1'b1;
            phase_nxt = PH_TYPE;
            if (ac_cur != COUNT_MAX) accepted_nxt = ac_cur + 14'd1;
          end else begin
            value_counter_nxt = 16'd0;
            phase_nxt         = PH_VALUE;
          end
        end
        default: begin
          cls   = CLS_VALUE;
          vidx  = vc_cur;
          vbyte = data_byte;
          if ({1'b0, vc_cur} + 17'd1 >= {1'b0, hl_cur}) begin
            done              = 1'b1;
            value_counter_nxt = 16'd0;
            phase_nxt         = PH_TYPE;
            if (ac_cur != COUNT_MAX) accepted_nxt = ac_cur + 14'd1;
          end else begin
            value_counter_nxt = vc_cur + 16'd1;
          end
        end
      endcase
    end

    byte_offset_nxt = (off != '1) ? off + LENGTH_BITS'(1) : off;

    result             = '0;
    result.byte_class  = cls;
    result.stop_reason = stopped_nxt;
    result.ie_count    = accepted_nxt;
    result.buffer_end  = (off_e + EW'(1) == tl_e);
    if (cls != CLS_DISCARD) begin
      result.ie_type     = held_type_nxt;
      result.ie_len      = held_length_nxt;
      result.ie_instance = held_inst_cr_nxt[4:1];
      result.cr_flag     = held_inst_cr_nxt[0];
      result.value_index = vidx;
      result.value_byte  = vbyte;
      result.ie_complete = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= '0;
      total_length_r  <= '0;
      phase_r         <= PH_TYPE;
      held_type_r     <= 8'd0;
      held_length_r   <= 16'd0;
      held_inst_cr_r  <= 5'd0;
      value_counter_r <= 16'd0;
      stopped_r       <= STOP_NONE;
      accepted_r      <= 14'd0;
    end else if (step) begin
      byte_offset_r   <= byte_offset_nxt;
      total_length_r  <= total_length_nxt;
      phase_r         <= phase_nxt;
      held_type_r     <= held_type_nxt;
      held_length_r   <= held_length_nxt;
      held_inst_cr_r  <= held_inst_cr_nxt;
      value_counter_r <= value_counter_nxt;
      stopped_r       <= stopped_nxt;
      accepted_r      <= accepted_nxt;
    end
  end

endmodule

### rtl/core/gtpv2_ie_tlv_deframer_core.sv
// gtpv2_ie_tlv_deframer_core: top level, input register, parser and result register
// depends on gtpie_pkg and gtpie_parser
//
// One byte of a GTPv2 IE buffer enters per item and one tagged result leaves per item.
// The core sustains one item per clock unless a low out_tready holds it: an input register
// feeds the parser, whose short logic updates the parse state as the item moves into
// the result register, so the result of an item passes the input register and then the
// result register. The result register holds while out_tready is low and the input register
// still takes one more item behind it. The first byte of a buffer (in_tuser high) brings
// the buffer length and restarts parsing; out_tlast marks the last byte of the buffer.
module gtpv2_ie_tlv_deframer_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], buffer_length[23:8]
  input  logic        in_tuser,   // first
  output logic        out_tvalid,
  input  logic        out_tready,
  // stop_reason[1:0], ie_type[9:2], ie_len[25:10], ie_instance[29:26], cr_flag[30],
  // value_index[46:31], value_byte[54:47], ie_complete[55], ie_count[69:56], zero[71:70]
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // byte_class
  output logic        out_tlast   // buffer_end
);
  import gtpie_pkg::*;

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          in_first_r;
  logic [15:0]   in_blen_r;
  logic          out_valid_r;
  gtpie_result_t out_res_r;
  gtpie_result_t res;
  logic          advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata[7:0];
      in_blen_r  <= in_tdata[23:8];
      in_first_r <= in_tuser;
    end
  end

  gtpie_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .data_byte    (in_byte_r),
    .first        (in_first_r),
    .buffer_length(in_blen_r),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.byte_class;
  assign out_tlast  = out_res_r.buffer_end;
  assign out_tdata  = {
    (OUT_TDATA_W - 70)'(0),
    out_res_r.ie_count,
    out_res_r.ie_complete,
    out_res_r.value_byte,
    out_res_r.value_index,
    out_res_r.cr_flag,
    out_res_r.ie_instance,
    out_res_r.ie_len,
    out_res_r.ie_type,
    out_res_r.stop_reason
  };

endmodule
